// ===== src/rotate_point_about_pivot_macros.svh =====
// Assertion helpers for the point rotation block.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef ROTATE_POINT_ABOUT_PIVOT_MACROS_SVH
`define ROTATE_POINT_ABOUT_PIVOT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RPAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define RPAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rpap_pkg.sv =====
package rpap_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ATAN_COUNT        = 30;

    // CORDIC datapath widths: x and y in Q2.30 with headroom, z as a turn fraction
    localparam int XW = 34;
    localparam int ZW = 32;

    // 2^64 per full turn, per radian and per degree
    localparam logic [63:0] TURN_PER_RAD = 64'd2935890503282001226;
    localparam logic [63:0] TURN_PER_DEG = 64'd51240955760304310;

    localparam logic signed [XW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30         = 34'sd1073741824;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
    localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] angle;
        logic               angle_in_degrees;
    } item_t;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
    } result_t;

    // Offset from the pivot and the values carried alongside the angle path
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] pz;
    } side_t;

endpackage

// ===== src/rpap_stream_if.sv =====
interface rpap_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rotate_point_about_pivot.sv =====
// Stages: multiply, phase, quadrant, one per CORDIC iteration, trig, product, sum and
// output. Throughput: one word per cycle while the sink takes results; a stage holds
// only when the sink stalls and it and every stage below it are full.
// Reset: rst_n clears all stage valid bits asynchronously; data registers are not reset.
module rotate_point_about_pivot #(
    parameter int CORDIC_STEPS  = rpap_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = rpap_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rpap_stream_if.sink   item,
    rpap_stream_if.source result
);
    import rpap_pkg::*;

    // The arctangent table stops at 30 entries
    localparam int NSTEP = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

    // Stage map
    localparam int ST_MUL   = 0;
    localparam int ST_PHASE = 1;
    localparam int ST_QUAD  = 2;
    localparam int ST_CRD0  = 3;
    localparam int ST_TRIG  = ST_CRD0 + NSTEP;
    localparam int ST_PROD  = ST_TRIG + 1;
    localparam int ST_SUM   = ST_PROD + 1;
    localparam int ST_OUT   = ST_SUM + 1;
    localparam int NST      = ST_OUT + 1;

    // Angle to phase scale, rounded to the angle's fraction bits.
    // The 64-bit wrap of angle * scale is the reduction modulo a full turn.
    localparam logic [63:0] KF_RAD =
        (TURN_PER_RAD + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    localparam logic [63:0] KF_DEG =
        (TURN_PER_DEG + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;

    localparam logic [63:0]        PHASE_HALF = 64'h0000_0000_8000_0000;
    localparam logic [31:0]        QUAD_HALF  = 32'h2000_0000;
    localparam logic signed [65:0] PROD_HALF  = 66'sd536870912;

    function automatic logic signed [31:0] clamp_unit(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        begin
            if (v > ONE_Q30)
                t = ONE_Q30;
            else if (v < -ONE_Q30)
                t = -ONE_Q30;
            else
                t = v;
            return 32'(t);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        begin
            if (v > 37'sh0_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (v < -37'sh0_8000_0000)
                return 32'sh8000_0000;
            else
                return 32'(v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Flow control: valid bit per stage. A stage may load whenever the
    // sink takes a word or any stage at or below it holds a bubble, so
    // bubbles collapse and the input keeps flowing while a result waits.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = result.ready || !(&vld_reg[NST-1:k]);
    end

    assign vld_next = (en & {vld_reg[NST-2:0], item.valid}) | (~en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign item.ready   = en[ST_MUL];
    assign result.valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Side band: offsets, pivot and z ride along with the angle path
    // ------------------------------------------------------------------
    side_t side_reg [NST];
    side_t side_next;

    always_comb
    begin
        side_next.dx = 33'(item.data.point_x) - 33'(item.data.pivot_x);
        side_next.dy = 33'(item.data.point_y) - 33'(item.data.pivot_y);
        side_next.cx = item.data.pivot_x;
        side_next.cy = item.data.pivot_y;
        side_next.pz = item.data.point_z;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
            side_reg[ST_MUL] <= side_next;
    end

    for (genvar k = 1; k < NST; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Angle scaling: split the scale into two 32-bit halves so each
    // multiplier stays near 32x32; only the low 32 bits of the high part
    // survive the 64-bit wrap.
    // ------------------------------------------------------------------
    logic [63:0]        kf_sel;
    logic signed [64:0] mlo_next;
    logic [31:0]        mhi_next;
    logic [63:0]        mlo_reg;
    logic [31:0]        mhi_reg;

    assign kf_sel   = item.data.angle_in_degrees ? KF_DEG : KF_RAD;
    assign mlo_next = item.data.angle * $signed({1'b0, kf_sel[31:0]});
    assign mhi_next = $unsigned(item.data.angle) * kf_sel[63:32];

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            mlo_reg <= mlo_next[63:0];
            mhi_reg <= mhi_next;
        end
    end

    // Round to a 32-bit phase, 2^32 per turn
    logic [63:0] mlo_rnd;
    logic [31:0] phase_next;
    logic [31:0] phase_reg;

    assign mlo_rnd    = mlo_reg + PHASE_HALF;
    assign phase_next = mlo_rnd[63:32] + mhi_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PHASE])
            phase_reg <= phase_next;
    end

    // ------------------------------------------------------------------
    // Quadrant split: nearest quarter turn and a residual within +-1/8 turn
    // ------------------------------------------------------------------
    logic signed [XW-1:0] crd_x_reg [NSTEP+1];
    logic signed [XW-1:0] crd_y_reg [NSTEP+1];
    logic signed [ZW-1:0] crd_z_reg [NSTEP+1];
    logic [1:0]           crd_q_reg [NSTEP+1];

    logic [31:0] quad_off;
    logic [1:0]  quad_next;
    logic [31:0] resid_next;

    assign quad_off   = phase_reg + QUAD_HALF;
    assign quad_next  = quad_off[31:30];
    assign resid_next = phase_reg - {quad_next, 30'd0};

    always_ff @(posedge clk)
    begin
        if (en[ST_QUAD])
        begin
            crd_x_reg[0] <= CORDIC_INV_GAIN;
            crd_y_reg[0] <= '0;
            crd_z_reg[0] <= $signed(resid_next);
            crd_q_reg[0] <= quad_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation: one iteration per stage, fixed shift per stage
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NSTEP; i++) begin : g_crd
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        assign xs = crd_x_reg[i] >>> i;
        assign ys = crd_y_reg[i] >>> i;

        always_comb
        begin
            if (!crd_z_reg[i][ZW-1])
            begin
                x_next = crd_x_reg[i] - ys;
                y_next = crd_y_reg[i] + xs;
                z_next = crd_z_reg[i] - $signed(ATAN_TURN[i]);
            end
            else
            begin
                x_next = crd_x_reg[i] + ys;
                y_next = crd_y_reg[i] - xs;
                z_next = crd_z_reg[i] + $signed(ATAN_TURN[i]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_CRD0+i])
            begin
                crd_x_reg[i+1] <= x_next;
                crd_y_reg[i+1] <= y_next;
                crd_z_reg[i+1] <= z_next;
                crd_q_reg[i+1] <= crd_q_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Map back to the full angle and clamp cos/sin to [-1, 1] in Q2.30
    // ------------------------------------------------------------------
    logic signed [XW-1:0] c_raw;
    logic signed [XW-1:0] s_raw;
    logic signed [31:0]   cs_next;
    logic signed [31:0]   sn_next;
    logic signed [31:0]   cs_reg;
    logic signed [31:0]   sn_reg;

    always_comb
    begin
        case (crd_q_reg[NSTEP])
            QUAD_I:
            begin
                c_raw = crd_x_reg[NSTEP];
                s_raw = crd_y_reg[NSTEP];
            end
            QUAD_II:
            begin
                c_raw = -crd_y_reg[NSTEP];
                s_raw = crd_x_reg[NSTEP];
            end
            QUAD_III:
            begin
                c_raw = -crd_x_reg[NSTEP];
                s_raw = -crd_y_reg[NSTEP];
            end
            default:
            begin
                c_raw = crd_y_reg[NSTEP];
                s_raw = -crd_x_reg[NSTEP];
            end
        endcase
        cs_next = clamp_unit(c_raw);
        sn_next = clamp_unit(s_raw);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_TRIG])
        begin
            cs_reg <= cs_next;
            sn_reg <= sn_next;
        end
    end

    // ------------------------------------------------------------------
    // Rotate the offset: four 33x32 products, registered
    // ------------------------------------------------------------------
    logic signed [64:0] p_xc_next;
    logic signed [64:0] p_ys_next;
    logic signed [64:0] p_xs_next;
    logic signed [64:0] p_yc_next;
    logic signed [64:0] p_xc_reg;
    logic signed [64:0] p_ys_reg;
    logic signed [64:0] p_xs_reg;
    logic signed [64:0] p_yc_reg;

    assign p_xc_next = side_reg[ST_TRIG].dx * cs_reg;
    assign p_ys_next = side_reg[ST_TRIG].dy * sn_reg;
    assign p_xs_next = side_reg[ST_TRIG].dx * sn_reg;
    assign p_yc_next = side_reg[ST_TRIG].dy * cs_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            p_xc_reg <= p_xc_next;
            p_ys_reg <= p_ys_next;
            p_xs_reg <= p_xs_next;
            p_yc_reg <= p_yc_next;
        end
    end

    // Combine, round and drop the 30 fraction bits (floor)
    logic signed [65:0] sum_x;
    logic signed [65:0] sum_y;
    logic signed [35:0] nxs_next;
    logic signed [35:0] nys_next;
    logic signed [35:0] nxs_reg;
    logic signed [35:0] nys_reg;

    assign sum_x    = 66'(p_xc_reg) - 66'(p_ys_reg) + PROD_HALF;
    assign sum_y    = 66'(p_xs_reg) + 66'(p_yc_reg) + PROD_HALF;
    assign nxs_next = $signed(sum_x[65:30]);
    assign nys_next = $signed(sum_y[65:30]);

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            nxs_reg <= nxs_next;
            nys_reg <= nys_next;
        end
    end

    // Add the pivot back and saturate into the output register
    logic signed [36:0] tx;
    logic signed [36:0] ty;
    logic signed [31:0] rx_next;
    logic signed [31:0] ry_next;
    logic signed [31:0] rx_reg;
    logic signed [31:0] ry_reg;

    assign tx      = 37'(nxs_reg) + 37'(side_reg[ST_SUM].cx);
    assign ty      = 37'(nys_reg) + 37'(side_reg[ST_SUM].cy);
    assign rx_next = sat32(tx);
    assign ry_next = sat32(ty);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign result.data.rotated_x = rx_reg;
    assign result.data.rotated_y = ry_reg;
    assign result.data.rotated_z = side_reg[ST_OUT].pz;

endmodule

// ===== src/rpap_checker.sv =====
`include "rotate_point_about_pivot_macros.svh"

module rpap_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input rpap_pkg::result_t out_data
);
    import rpap_pkg::*;

    result_t out_data_q;
    assign out_data_q = out_data;

    // Input never stalls while the output side is free
    `RPAP_ASSERT_NOW(a_ready_when_free, (!out_valid || out_ready), in_ready, "input stalled with free output")

    // Pipeline comes out of reset empty
    `RPAP_ASSERT_NOW(a_empty_after_reset, $rose(rst_n), !out_valid, "result valid right after reset")

    // Hold a waiting result
    `RPAP_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), out_valid, "result dropped while stalled")

    // Hold its word
    `RPAP_ASSERT_NEXT(a_out_stable, (out_valid && !out_ready), $stable(out_data_q), "result changed while stalled")

endmodule

bind rotate_point_about_pivot rpap_checker u_rpap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
